// ----- src/dbla_pkg.sv -----
// ----------------------------------------------------------------------------
// dbla_pkg
// Shared constants and types for the double-buffered line assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package dbla_pkg;

   // Line geometry
   localparam int LINE_CAPACITY = 81;
   localparam int CNT_W         = 7;                  // fill count, 0..LINE_CAPACITY
   localparam int POS_W         = 7;                  // byte position inside one buffer
   localparam int STORE_AW      = POS_W + 1;          // buffer select plus position
   localparam int STORE_DEPTH   = 2 ** STORE_AW;

   // Queue between front and back
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_W    = 2;
   localparam int FIFO_LVL_W    = 3;

   // Item kinds
   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;

   // Character codes
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;

   typedef struct packed {
      logic             line_ready;
      logic             line_dropped;
      logic             line_buffer;
      logic [CNT_W-1:0] line_length;
      logic [7:0]       read_data;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- src/dbla_ram.sv -----
// ----------------------------------------------------------------------------
// dbla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dbla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- src/dbla_front.sv -----
// ----------------------------------------------------------------------------
// dbla_front
// Accepts items, updates line state, writes and reads the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module dbla_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [1:0]                     req_kind,
   input  wire logic [7:0]                     req_char_byte,
   input  wire logic [6:0]                     req_read_index,
   input  wire logic [dbla_pkg::FIFO_LVL_W-1:0] fifo_level,
   output      logic                           push_valid,
   output      dbla_pkg::rsp_word_type         push_word
);
   import dbla_pkg::*;

   logic [CNT_W-1:0]    cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;
   logic                active_ff, active_in;
   logic                held_ff, held_in;
   logic                busy_ff, busy_in;
   logic                s1_valid_ff;
   logic                s1_hit_ff, hit_in;
   rsp_word_type        s1_word_ff, word_in;
   logic [CNT_W-1:0]    cnt_act, cnt_held, cnt_act_in, cnt_held_in;
   logic                accept;
   logic                wr_en;
   logic [POS_W-1:0]    wr_pos;
   logic [7:0]          wr_data;
   logic [7:0]          rd_data;
   logic [FIFO_LVL_W:0] in_flight;

   // Hold off while the queue could not take everything in flight
   assign in_flight = {1'b0, fifo_level} + (FIFO_LVL_W+1)'(s1_valid_ff);
   assign req_stall = (in_flight >= (FIFO_LVL_W+1)'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign cnt_act  = active_ff ? cnt1_ff : cnt0_ff;
   assign cnt_held = held_ff   ? cnt1_ff : cnt0_ff;

   always_comb begin
      active_in   = active_ff;
      held_in     = held_ff;
      busy_in     = busy_ff;
      cnt_act_in  = cnt_act;
      cnt_held_in = cnt_held;
      wr_en       = 1'b0;
      wr_pos      = POS_W'(cnt_act);
      wr_data     = req_char_byte;
      hit_in      = 1'b0;
      word_in     = '0;
      if (accept) begin
         case (req_kind)
            KIND_CHAR: begin
               if (cnt_act >= CNT_W'(LINE_CAPACITY)) begin
                  // Full buffer: restart it with this byte, whatever it is
                  wr_en      = 1'b1;
                  wr_pos     = '0;
                  cnt_act_in = CNT_W'(1);
               end else if (req_char_byte == CH_CR) begin
                  cnt_act_in = cnt_act;
               end else if (req_char_byte == CH_LF) begin
                  if (!busy_ff) begin
                     wr_en               = 1'b1;
                     wr_data             = 8'h00;
                     cnt_act_in          = CNT_W'(cnt_act + 1'b1);
                     busy_in             = 1'b1;
                     held_in             = active_ff;
                     active_in           = !active_ff;
                     word_in.line_ready  = 1'b1;
                     word_in.line_length = CNT_W'(cnt_act + 1'b1);
                  end else begin
                     cnt_act_in           = '0;
                     word_in.line_dropped = 1'b1;
                  end
               end else if (req_char_byte inside {[CH_SPACE:CH_TILDE]}) begin
                  wr_en      = 1'b1;
                  cnt_act_in = CNT_W'(cnt_act + 1'b1);
               end
            end
            KIND_RELEASE: begin
               busy_in     = 1'b0;
               cnt_held_in = '0;
            end
            KIND_READ: begin
               hit_in = (req_read_index < cnt_held);
            end
            default: ;
         endcase
      end
      word_in.line_buffer = held_in;
   end

   // At most one of the two counts changes per item
   always_comb begin
      cnt0_in = cnt0_ff;
      cnt1_in = cnt1_ff;
      if (accept && req_kind == KIND_CHAR) begin
         if (active_ff) cnt1_in = cnt_act_in;
         else           cnt0_in = cnt_act_in;
      end else if (accept && req_kind == KIND_RELEASE) begin
         if (held_ff) cnt1_in = cnt_held_in;
         else         cnt0_in = cnt_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt0_ff     <= '0;
         cnt1_ff     <= '0;
         active_ff   <= 1'b0;
         held_ff     <= 1'b0;
         busy_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         cnt0_ff     <= cnt0_in;
         cnt1_ff     <= cnt1_in;
         active_ff   <= active_in;
         held_ff     <= held_in;
         busy_ff     <= busy_in;
         s1_valid_ff <= accept;
      end
      s1_word_ff <= word_in;
      s1_hit_ff  <= hit_in;
   end

   dbla_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({active_ff, wr_pos}),
      .wr_data (wr_data),
      .rd_addr ({held_ff, req_read_index}),
      .rd_data (rd_data)
   );

   always_comb begin
      push_word           = s1_word_ff;
      push_word.read_data = s1_hit_ff ? rd_data : 8'h00;
   end
   assign push_valid = s1_valid_ff;

endmodule

`default_nettype wire

// ----- src/dbla_back.sv -----
// ----------------------------------------------------------------------------
// dbla_back
// Result queue; delivers words on the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dbla_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push_valid,
   input  wire dbla_pkg::rsp_word_type          push_word,
   output      logic [dbla_pkg::FIFO_LVL_W-1:0] fifo_level,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic                            rsp_line_ready,
   output      logic                            rsp_line_dropped,
   output      logic                            rsp_line_buffer,
   output      logic [6:0]                      rsp_line_length,
   output      logic [7:0]                      rsp_read_data
);
   import dbla_pkg::*;

   rsp_word_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_W-1:0]   count_ff, count_in;
   logic                    pop;
   rsp_word_type            head;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push_valid ? FIFO_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? FIFO_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      case ({push_valid, pop})
         2'b10:   count_in = FIFO_LVL_W'(count_ff + 1'b1);
         2'b01:   count_in = FIFO_LVL_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign fifo_level       = count_ff;
   assign rsp_line_ready   = head.line_ready;
   assign rsp_line_dropped = head.line_dropped;
   assign rsp_line_buffer  = head.line_buffer;
   assign rsp_line_length  = head.line_length;
   assign rsp_read_data    = head.read_data;

endmodule

`default_nettype wire

// ----- src/double_buffered_line_assembler_core.sv -----
// ----------------------------------------------------------------------------
// double_buffered_line_assembler_core
// Assembles received characters into lines in two ping-pong buffers.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall): each word carries a kind, a
// character byte and a read index. Kind selects character, release of the
// held line, or read of one byte of the held line. Every accepted word
// produces exactly one response word on rsp_valid / rsp_stall, in order.
//
// A response is registered with the state update and line store read,
// then queued. Throughput: one word per cycle while req_stall is low;
// the line store is a single-write, single-read RAM, and each word needs
// at most one access of each kind.
//
// Reset clears fill counts, buffer selects, the busy flag and the queue.
// The line store is not cleared; only bytes below a fill count are read.
// When the receiver stalls, results collect in a 4-entry queue; req_stall
// rises once the queue plus the word in flight would fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module double_buffered_line_assembler_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_char_byte,
   input  wire logic [6:0] req_read_index,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_line_ready,
   output      logic       rsp_line_dropped,
   output      logic       rsp_line_buffer,
   output      logic [6:0] rsp_line_length,
   output      logic [7:0] rsp_read_data
);
   import dbla_pkg::*;

   logic                  push_valid;
   rsp_word_type          push_word;
   logic [FIFO_LVL_W-1:0] fifo_level;

   dbla_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_char_byte  (req_char_byte),
      .req_read_index (req_read_index),
      .fifo_level     (fifo_level),
      .push_valid     (push_valid),
      .push_word      (push_word)
   );

   dbla_back u_back (
      .clock            (clock),
      .reset            (reset),
      .push_valid       (push_valid),
      .push_word        (push_word),
      .fifo_level       (fifo_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_ready   (rsp_line_ready),
      .rsp_line_dropped (rsp_line_dropped),
      .rsp_line_buffer  (rsp_line_buffer),
      .rsp_line_length  (rsp_line_length),
      .rsp_read_data    (rsp_read_data)
   );

endmodule

`default_nettype wire

// ----- src/dbla_checker.sv -----
// ----------------------------------------------------------------------------
// dbla_checker
// Port-level checks for the line assembler core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dbla_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_kind,
   input wire logic [7:0] req_char_byte,
   input wire logic [6:0] req_read_index,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_line_ready,
   input wire logic       rsp_line_dropped,
   input wire logic       rsp_line_buffer,
   input wire logic [6:0] rsp_line_length,
   input wire logic [7:0] rsp_read_data
);

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_ready)
         && $stable(rsp_line_dropped) && $stable(rsp_line_buffer)
         && $stable(rsp_line_length) && $stable(rsp_read_data))
      else $error("response word changed while stalled");

   // A line feed either hands over or drops, never both
   a_ready_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_line_ready && rsp_line_dropped))
      else $error("line both handed over and dropped");

   // A handed line has at least its terminator and no read data
   a_ready_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_ready |-> rsp_line_length != 7'd0 && rsp_read_data == 8'd0)
      else $error("hand-over with empty length or read data");

   // Length is reported only on a hand-over
   a_length_only_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_ready |-> rsp_line_length == 7'd0)
      else $error("line length without hand-over");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

endmodule

bind double_buffered_line_assembler_core dbla_checker u_dbla_checker (.*);

`default_nettype wire

// ----- sim/tb_double_buffered_line_assembler_core.sv -----
// ----------------------------------------------------------------------------
// tb_double_buffered_line_assembler_core
// Self-checking bench for the ping-pong line assembler. A queue of words
// (directed, then random lines, reads, releases and noise) feeds a driver;
// a monitor predicts each accepted word and checks the responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_double_buffered_line_assembler_core;
   import dbla_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         WORD_TARGET = 2000;
   localparam int         IDLE_LIMIT  = 1000;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_byte;
      logic [6:0] read_index;
   } line_cmd_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_kind;
   logic [7:0] req_char_byte;
   logic [6:0] req_read_index;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_line_ready;
   logic       rsp_line_dropped;
   logic       rsp_line_buffer;
   logic [6:0] rsp_line_length;
   logic [7:0] rsp_read_data;

   double_buffered_line_assembler_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_char_byte    (req_char_byte),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_ready   (rsp_line_ready),
      .rsp_line_dropped (rsp_line_dropped),
      .rsp_line_buffer  (rsp_line_buffer),
      .rsp_line_length  (rsp_line_length),
      .rsp_read_data    (rsp_read_data)
   );

   line_cmd_type pending_cmds[$];
   rsp_word_type expected_rsp[$];
   int           error_count;
   int           counted_words;

   // Predicted assembler state
   logic [7:0] asm_bytes [0:1][0:LINE_CAPACITY-1];
   int         asm_fill  [0:1];
   logic       asm_active;
   logic       asm_held;
   logic       asm_busy;

   // Handshake bookkeeping
   logic req_taken;
   logic rsp_taken;
   int   req_wait;
   int   rsp_wait;
   logic req_burst;
   logic rsp_burst;
   int   idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_word_type assemble_line_word(line_cmd_type cmd);
      rsp_word_type w;
      logic         sel;
      int           cnt;
      w = '0;
      case (cmd.kind)
         KIND_CHAR: begin
            sel = asm_active;
            cnt = asm_fill[sel];
            if (cnt >= LINE_CAPACITY) begin
               // full buffer: restart at position 0 with the raw byte
               asm_bytes[sel][0] = cmd.char_byte;
               asm_fill[sel] = 1;
            end else if (cmd.char_byte == CH_CR) begin
               // drop carriage return
            end else if (cmd.char_byte == CH_LF) begin
               if (!asm_busy) begin
                  asm_bytes[sel][cnt] = 8'h00;
                  cnt++;
                  asm_fill[sel] = cnt;
                  asm_busy = 1'b1;
                  asm_held = sel;
                  asm_active = ~sel;
                  w.line_ready = 1'b1;
                  w.line_length = cnt[6:0];
               end else begin
                  asm_fill[sel] = 0;
                  w.line_dropped = 1'b1;
               end
            end else if (cmd.char_byte >= CH_SPACE && cmd.char_byte <= CH_TILDE) begin
               asm_bytes[sel][cnt] = cmd.char_byte;
               asm_fill[sel] = cnt + 1;
            end
         end
         KIND_RELEASE: begin
            asm_busy = 1'b0;
            asm_fill[asm_held] = 0;
            for (int i = 0; i < LINE_CAPACITY; i++) asm_bytes[asm_held][i] = 8'h00;
         end
         KIND_READ: begin
            if (int'(cmd.read_index) < asm_fill[asm_held])
               w.read_data = asm_bytes[asm_held][cmd.read_index];
         end
         default: begin
         end
      endcase
      w.line_buffer = asm_held;
      return w;
   endfunction

   task automatic push_cmd(logic [1:0] kind, logic [7:0] ch, logic [6:0] idx);
      line_cmd_type cmd;
      cmd.kind = kind;
      cmd.char_byte = ch;
      cmd.read_index = idx;
      pending_cmds.push_back(cmd);
      counted_words++;
   endtask

   function automatic logic [7:0] line_char();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return CH_CR;
      if (r == 1) return 8'($urandom_range(0, 31));
      if (r == 2) return 8'($urandom_range(127, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // Driver: present words at the falling edge, hold while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_wait > 0) begin
            req_valid <= 1'b0;
            req_wait <= req_wait - 1;
         end else if (pending_cmds.size() != 0) begin
            line_cmd_type cmd;
            cmd = pending_cmds.pop_front();
            req_kind <= cmd.kind;
            req_char_byte <= cmd.char_byte;
            req_read_index <= cmd.read_index;
            req_valid <= 1'b1;
            if ($urandom_range(0, 24) == 0) req_burst <= ~req_burst;
            req_wait <= req_burst ? 0 : $urandom_range(0, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: draw a stall stretch after every accepted response
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_taken) begin
         int n;
         if ($urandom_range(0, 24) == 0) rsp_burst <= ~rsp_burst;
         n = rsp_burst ? 0 : $urandom_range(0, 13);
         rsp_stall <= (n > 0);
         rsp_wait <= (n > 0) ? n - 1 : 0;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check responses, then predict the word accepted at this edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response: expected none, got ready %0d dropped %0d",
                        $time, rsp_line_ready, rsp_line_dropped);
               error_count++;
            end else begin
               rsp_word_type w;
               w = expected_rsp.pop_front();
               check_field("line_ready", w.line_ready, rsp_line_ready);
               check_field("line_dropped", w.line_dropped, rsp_line_dropped);
               check_field("line_buffer", w.line_buffer, rsp_line_buffer);
               check_field("line_length", w.line_length, rsp_line_length);
               check_field("read_data", w.read_data, rsp_read_data);
            end
         end
         if (req_valid && !req_stall) begin
            line_cmd_type cmd;
            cmd.kind = req_kind;
            cmd.char_byte = req_char_byte;
            cmd.read_index = req_read_index;
            expected_rsp.push_back(assemble_line_word(cmd));
         end
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int len;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_CHAR;
      req_char_byte = 8'h00;
      req_read_index = 7'd0;
      rsp_stall = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      req_wait = 0;
      rsp_wait = 0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      idle_cycles = 0;
      error_count = 0;
      counted_words = 0;
      asm_active = 1'b0;
      asm_held = 1'b0;
      asm_busy = 1'b0;
      for (int b = 0; b < 2; b++) begin
         asm_fill[b] = 0;
         for (int i = 0; i < LINE_CAPACITY; i++) asm_bytes[b][i] = 8'h00;
      end

      // Directed: empty read, byte extremes, hand-over, reads past the end,
      // drop while busy, the unused kind and release while idle
      push_cmd(KIND_READ, 8'h00, 7'd0);
      push_cmd(KIND_CHAR, CH_SPACE, 7'd0);
      push_cmd(KIND_CHAR, CH_TILDE, 7'd0);
      push_cmd(KIND_CHAR, CH_CR, 7'd0);
      push_cmd(KIND_CHAR, 8'h00, 7'd0);
      push_cmd(KIND_CHAR, 8'hFF, 7'd0);
      push_cmd(KIND_CHAR, 8'h1F, 7'd0);
      push_cmd(KIND_CHAR, 8'h7F, 7'd0);
      push_cmd(KIND_CHAR, 8'h41, 7'd0);
      push_cmd(KIND_CHAR, CH_LF, 7'd0);
      push_cmd(KIND_READ, 8'h00, 7'd0);
      push_cmd(KIND_READ, 8'h00, 7'd2);
      push_cmd(KIND_READ, 8'h00, 7'd3);
      push_cmd(KIND_READ, 8'h00, 7'd4);
      push_cmd(KIND_READ, 8'h00, 7'd80);
      push_cmd(KIND_CHAR, 8'h42, 7'd0);
      push_cmd(KIND_CHAR, CH_LF, 7'd0);
      push_cmd(KIND_UNUSED, 8'hFF, 7'h7F);
      push_cmd(KIND_RELEASE, 8'h00, 7'd0);
      push_cmd(KIND_RELEASE, 8'hFF, 7'h7F);
      push_cmd(KIND_READ, 8'h00, 7'd0);

      // Random: mostly whole lines with reads and a release, some noise
      while (counted_words < WORD_TARGET) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 9) == 0) begin
               // fill the buffer nearly or fully; when full, store one raw byte at position 0
               len = $urandom_range(76, LINE_CAPACITY);
               for (int i = 0; i < len; i++)
                  push_cmd(KIND_CHAR, 8'($urandom_range(32, 126)), 7'd0);
               if (len == LINE_CAPACITY) begin
                  n = $urandom_range(0, 3);
                  push_cmd(KIND_CHAR, n == 0 ? CH_LF : n == 1 ? CH_CR :
                           8'($urandom_range(0, 255)), 7'd0);
                  len = $urandom_range(0, 4);
                  for (int i = 0; i < len; i++) push_cmd(KIND_CHAR, line_char(), 7'd0);
               end
            end else begin
               len = $urandom_range(0, 16);
               for (int i = 0; i < len; i++) push_cmd(KIND_CHAR, line_char(), 7'd0);
            end
            push_cmd(KIND_CHAR, CH_LF, 7'd0);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
               push_cmd(KIND_READ, 8'($urandom_range(0, 255)),
                        7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 80)
                                                     : $urandom_range(0, 18)));
            // leave the line held now and then so the next one is dropped
            if ($urandom_range(0, 3) != 0)
               push_cmd(KIND_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 80)));
         end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               push_cmd(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                        7'($urandom_range(0, 80)));
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_cmds.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $display("%0t: %0d responses expected, got none", $time, expected_rsp.size());
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
